### rtl/core/rtn_pkg.sv
package rtn_pkg;

  // Register indexes on the configuration port
  localparam logic REG_LINE_WIDTH   = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int CFG_W  = 13;
  localparam int SIZE_W = 16;
  localparam int ROW_W  = 12;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RESET   = 13'd1920;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd1080;
  localparam logic [CFG_W-1:0] HEIGHT_LIMIT       = 13'd4096;

  localparam int DEF_MAX_WIDTH = 4096;
  localparam int QUEUE_DEPTH   = 4;

  // Rec.601 weights, Q16, as magnitudes
  localparam logic [15:0] KY_R = 16'd16829;
  localparam logic [15:0] KY_G = 16'd33039;
  localparam logic [15:0] KY_B = 16'd6416;
  localparam logic [15:0] KB_R = 16'd9713;
  localparam logic [15:0] KB_G = 16'd19069;
  localparam logic [15:0] KB_B = 16'd28784;
  localparam logic [15:0] KR_R = 16'd28784;
  localparam logic [15:0] KR_G = 16'd24102;
  localparam logic [15:0] KR_B = 16'd4680;

  localparam logic [23:0] ROUND_HALF  = 24'd32768;
  // 128 << 16 plus rounding; keeps the chroma sums positive
  localparam logic [23:0] CHROMA_BIAS = 24'd8421376;
  localparam logic [7:0]  LUMA_OFFSET = 8'd16;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma;
    logic [7:0] cb;
    logic [7:0] cr;
  } job_t;

endpackage

### rtl/core/rtn_front.sv
module rtn_front #(
  parameter int MAX_WIDTH = rtn_pkg::DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [rtn_pkg::CFG_W-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               chan_red,
  input  logic [7:0]               chan_green,
  input  logic [7:0]               chan_blue,
  input  logic                     q_full,
  output logic                     push,
  output rtn_pkg::job_t            job
);

  localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int AW    = (CW > 1) ? CW - 1 : 1;
  localparam int DEPTH = MAX_WIDTH / 2;

  logic [rtn_pkg::CFG_W-1:0]  line_width;
  logic [rtn_pkg::CFG_W-1:0]  frame_height;
  logic [CW-1:0]              col;
  logic [rtn_pkg::ROW_W-1:0]  row;
  logic [rtn_pkg::SIZE_W-1:0] w_eff;
  logic [rtn_pkg::CFG_W-1:0]  h_eff;
  logic                       col_wrap;
  logic                       row_wrap;
  logic                       accept;
  logic                       adv;

  logic          s0_valid, s1_valid, s2_valid, s3_valid;
  logic [7:0]    s0_r, s0_g, s0_b;
  logic [1:0]    s0_pos, s1_pos, s2_pos, s3_pos;  // {row_odd, col_odd}
  logic [AW-1:0] s0_idx, s1_idx, s2_idx, s3_idx;
  logic [23:0]   p_yr, p_yg, p_yb, p_br, p_bg, p_bb, p_rr, p_rg, p_rb;
  logic [23:0]   y_sum, cb_sum, cr_sum;
  logic [7:0]    s2_y, s2_cb, s2_cr;
  logic [7:0]    s3_y, s3_cb, s3_cr;
  logic [15:0]   hold;
  logic [17:0]   line_sums [DEPTH];
  logic [17:0]   rd_data;
  logic [8:0]    cbp, crp;
  logic [9:0]    cbt, crt;

  assign adv      = !(s3_valid && q_full);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  always_comb begin
    if (line_width < rtn_pkg::CFG_W'(2)) begin
      w_eff = rtn_pkg::SIZE_W'(2);
    end else if (rtn_pkg::SIZE_W'(line_width) > rtn_pkg::SIZE_W'(MAX_WIDTH)) begin
      w_eff = rtn_pkg::SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = rtn_pkg::SIZE_W'(line_width);
    end
    if (frame_height < rtn_pkg::CFG_W'(2)) begin
      h_eff = rtn_pkg::CFG_W'(2);
    end else if (frame_height > rtn_pkg::HEIGHT_LIMIT) begin
      h_eff = rtn_pkg::HEIGHT_LIMIT;
    end else begin
      h_eff = frame_height;
    end
  end

  assign col_wrap = (rtn_pkg::SIZE_W'(col) + rtn_pkg::SIZE_W'(1)) >= w_eff;
  assign row_wrap = (rtn_pkg::CFG_W'(row) + rtn_pkg::CFG_W'(1)) >= h_eff;

  // Registers and raster position; a write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= rtn_pkg::LINE_WIDTH_RESET;
      frame_height <= rtn_pkg::FRAME_HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        rtn_pkg::REG_LINE_WIDTH:   line_width   <= cfg_data;
        rtn_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row + rtn_pkg::ROW_W'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= accept;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  assign y_sum  = rtn_pkg::ROUND_HALF + p_yr + p_yg + p_yb;
  assign cb_sum = rtn_pkg::CHROMA_BIAS + p_bb - p_br - p_bg;
  assign cr_sum = rtn_pkg::CHROMA_BIAS + p_rr - p_rg - p_rb;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r   <= chan_red;
      s0_g   <= chan_green;
      s0_b   <= chan_blue;
      s0_pos <= {row[0], col[0]};
      s0_idx <= AW'(col >> 1);
      p_yr   <= 24'(s0_r) * 24'(rtn_pkg::KY_R);
      p_yg   <= 24'(s0_g) * 24'(rtn_pkg::KY_G);
      p_yb   <= 24'(s0_b) * 24'(rtn_pkg::KY_B);
      p_br   <= 24'(s0_r) * 24'(rtn_pkg::KB_R);
      p_bg   <= 24'(s0_g) * 24'(rtn_pkg::KB_G);
      p_bb   <= 24'(s0_b) * 24'(rtn_pkg::KB_B);
      p_rr   <= 24'(s0_r) * 24'(rtn_pkg::KR_R);
      p_rg   <= 24'(s0_g) * 24'(rtn_pkg::KR_G);
      p_rb   <= 24'(s0_b) * 24'(rtn_pkg::KR_B);
      s1_pos <= s0_pos;
      s1_idx <= s0_idx;
      s2_y   <= rtn_pkg::LUMA_OFFSET + y_sum[23:16];
      s2_cb  <= cb_sum[23:16];
      s2_cr  <= cr_sum[23:16];
      s2_pos <= s1_pos;
      s2_idx <= s1_idx;
      s3_y   <= s2_y;
      s3_cb  <= s2_cb;
      s3_cr  <= s2_cr;
      s3_pos <= s2_pos;
      s3_idx <= s2_idx;
    end
  end

  // Line store: read as the item enters the last stage, write as it leaves
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= line_sums[s2_idx];
    end
    if (adv && s3_valid && s3_pos[0] && !s3_pos[1]) begin
      line_sums[s3_idx] <= {crp, cbp};
    end
    if (adv && s3_valid && !s3_pos[0]) begin
      hold <= {s3_cr, s3_cb};
    end
  end

  assign cbp = 9'(hold[7:0]) + 9'(s3_cb);
  assign crp = 9'(hold[15:8]) + 9'(s3_cr);
  assign cbt = 10'(rd_data[8:0]) + 10'(cbp) + 10'd2;
  assign crt = 10'(rd_data[17:9]) + 10'(crp) + 10'd2;

  assign push       = s3_valid && !q_full;
  assign job.luma   = s3_y;
  assign job.chroma = s3_pos[0] && s3_pos[1];
  assign job.cb     = cbt[9:2];
  assign job.cr     = crt[9:2];

endmodule

### rtl/core/rtn_queue.sv
module rtn_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rtn_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output rtn_pkg::job_t head
);

  localparam int DEPTH = rtn_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  rtn_pkg::job_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full  = count == (PW+1)'(DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("queue read while empty");

endmodule

### rtl/core/rtn_back.sv
module rtn_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  rtn_pkg::job_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          kind,
  output logic [7:0]    luma,
  output logic [7:0]    cb_value,
  output logic [7:0]    cr_value,
  output logic          last
);

  typedef enum logic [1:0] {
    PH_LUMA   = 2'b01,
    PH_CHROMA = 2'b10
  } phase_t;

  phase_t phase;
  logic   load;

  assign load = (!out_valid || !out_stall) && !q_empty;
  assign pop  = load && (phase == PH_CHROMA || !head.chroma);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= PH_LUMA;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        case (phase)
          PH_LUMA:   phase <= head.chroma ? PH_CHROMA : PH_LUMA;
          PH_CHROMA: phase <= PH_LUMA;
          default:   phase <= PH_LUMA;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      case (phase)
        PH_CHROMA: begin
          kind     <= 1'b1;
          luma     <= 8'd0;
          cb_value <= head.cb;
          cr_value <= head.cr;
          last     <= 1'b1;
        end
        default: begin
          kind     <= 1'b0;
          luma     <= head.luma;
          cb_value <= 8'd0;
          cr_value <= 8'd0;
          last     <= !head.chroma;
        end
      endcase
    end
  end

  a_chroma_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> last)
    else $error("chroma result not marked last");

  a_pending_chroma: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CHROMA |-> !q_empty)
    else $error("chroma pending without a queued job");

  a_luma_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> cb_value == 8'd0 && cr_value == 8'd0)
    else $error("luma result carries chroma");

endmodule

### rtl/core/rgb_to_nv12_convert.sv
// RGB to YCbCr 4:2:0 converter (Rec.601 studio range) for raster pixel streams.
//
// Input channel: in_valid / in_stall with chan_red, chan_green, chan_blue. A
// transaction moves one pixel. Output channel: out_valid / out_stall with kind,
// luma, cb_value, cr_value and last. Every pixel yields one luma transaction;
// the bottom-right pixel of each 2x2 block also yields an averaged chroma
// transaction right after its luma, and last marks the final one of a pixel.
// Odd trailing columns and rows give luma only.
// Configuration: cfg_write, cfg_index, cfg_data write line_width (index 0)
// or frame_height (index 1); either write restarts the frame at row 0.
// A result first shows on out_valid after its pixel's transaction passes the
// four pipeline stages, then the job queue into the output register.
// Throughput: one pixel per cycle while in_stall is low; the output register
// delivers one result per cycle while out_stall is low, so the extra chroma
// results of odd rows slow the pixel rate, set by that single output register.
// Reset: counters clear, line_width 1920, frame_height 1080; the line store
// holds no defined data until the even rows of the frame write it.
// Output stall: hold the result; the job queue fills and then in_stall
// rises, which freezes the whole front pipeline in place.
module rgb_to_nv12_convert #(
  parameter int MAX_WIDTH = rtn_pkg::DEF_MAX_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [rtn_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                chan_red,
  input  logic [7:0]                chan_green,
  input  logic [7:0]                chan_blue,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      kind,
  output logic [7:0]                luma,
  output logic [7:0]                cb_value,
  output logic [7:0]                cr_value,
  output logic                      last
);

  // Front pipeline -> job queue -> result sequencer
  rtn_pkg::job_t push_job;
  rtn_pkg::job_t head;
  logic          push;
  logic          q_full;
  logic          q_empty;
  logic          pop;

  rtn_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .chan_red  (chan_red),
    .chan_green(chan_green),
    .chan_blue (chan_blue),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  // Decouple the pixel pipeline from output backpressure
  rtn_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (pop),
    .empty   (q_empty),
    .head    (head)
  );

  // Expand each job into its luma and optional chroma transaction
  rtn_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind     (kind),
    .luma     (luma),
    .cb_value (cb_value),
    .cr_value (cr_value),
    .last     (last)
  );

endmodule
